// ----- design/qte_pkg.sv -----
// Package for the quaternion to Euler angle converter: widths, types, CORDIC helpers.
`timescale 1ns / 1ps
`default_nettype none
package qte_pkg;

  localparam int FRAC_BITS       = 14;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CORDIC_MAX      = 24;

  localparam int QW     = 16;   // quaternion component width
  localparam int PW     = 32;   // product width
  localparam int SUM_W  = 36;   // product sums and cosine terms
  localparam int CW     = 40;   // CORDIC x/y width
  localparam int ACC_W  = 34;   // angle accumulator, 2^31 = pi
  localparam int AW     = 16;   // output angle width
  localparam int SQ_W   = 64;   // square root remainder/root width
  localparam int SQRT_ITER = 32;

  localparam int SHL = (2 * FRAC_BITS <= 30) ? 30 - 2 * FRAC_BITS : 0;
  localparam int SHR = (2 * FRAC_BITS > 30) ? 2 * FRAC_BITS - 30 : 0;

  localparam logic signed [SUM_W-1:0] ONE  = SUM_W'(64'd1 << (2 * FRAC_BITS));
  localparam logic signed [SUM_W-1:0] RND  = (SHR > 0) ? SUM_W'(64'd1 << (SHR - 1)) : '0;
  localparam logic [SQ_W-1:0]         FULL = SQ_W'(64'd1 << 60);
  localparam logic signed [ACC_W-1:0] ACC_QTR = ACC_W'(64'd1 << 30);

  typedef struct packed {
    logic signed [SUM_W-1:0] sr;
    logic signed [SUM_W-1:0] cr;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] cy;
    logic signed [31:0]      s30;
    logic                    clamped;
  } sq_pay_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
    sq_pay_t         pay;
  } sq_t;

  typedef struct packed {
    logic signed [CW-1:0]    x;
    logic signed [CW-1:0]    y;
    logic signed [ACC_W-1:0] acc;
    logic                    zero;
  } vec_t;

  // lane 0 roll, lane 1 pitch, lane 2 yaw
  typedef struct packed {
    vec_t [2:0] lane;
    logic       clamped;
  } cd_t;

  function automatic logic signed [ACC_W-1:0] atan_of(input int i);
    logic signed [ACC_W-1:0] r;
    case (i)
      0:  r = ACC_W'(536870912);
      1:  r = ACC_W'(316933406);
      2:  r = ACC_W'(167458907);
      3:  r = ACC_W'(85004756);
      4:  r = ACC_W'(42667331);
      5:  r = ACC_W'(21354465);
      6:  r = ACC_W'(10679838);
      7:  r = ACC_W'(5340245);
      8:  r = ACC_W'(2670163);
      9:  r = ACC_W'(1335087);
      10: r = ACC_W'(667544);
      11: r = ACC_W'(333772);
      12: r = ACC_W'(166886);
      13: r = ACC_W'(83443);
      14: r = ACC_W'(41722);
      15: r = ACC_W'(20861);
      16: r = ACC_W'(10430);
      17: r = ACC_W'(5215);
      18: r = ACC_W'(2608);
      19: r = ACC_W'(1304);
      20: r = ACC_W'(652);
      21: r = ACC_W'(326);
      22: r = ACC_W'(163);
      23: r = ACC_W'(81);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Quadrant fold into the right half plane before the rotation stages.
  function automatic vec_t prerot(input logic signed [CW-1:0] y, input logic signed [CW-1:0] x);
    vec_t r;
    r.zero = (x == '0) && (y == '0);
    r.x    = x;
    r.y    = y;
    r.acc  = '0;
    if (x < 0) begin
      if (y >= 0) begin
        r.x   = y;
        r.y   = -x;
        r.acc = ACC_QTR;
      end else begin
        r.x   = -y;
        r.y   = x;
        r.acc = -ACC_QTR;
      end
    end
    return r;
  endfunction

  function automatic logic signed [AW-1:0] to_angle(input vec_t v);
    logic signed [ACC_W:0] rnd;
    rnd = {v.acc[ACC_W-1], v.acc} + (ACC_W+1)'(32768);
    return v.zero ? '0 : rnd[31:16];
  endfunction

endpackage
`default_nettype wire

// ----- design/qte_if.sv -----
// Valid/ready channel interfaces for quaternion input and Euler angle output.
`timescale 1ns / 1ps
`default_nettype none
interface qte_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qte_euler_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic               pitch_clamped;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                  input ready);
  modport sink (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                output ready);
endinterface
`default_nettype wire

// ----- design/qte_sqrt_cell.sv -----
// One restoring square root step (one root bit) with its own pipeline register.
`timescale 1ns / 1ps
`default_nettype none
module qte_sqrt_cell import qte_pkg::*; #(
  parameter int K = 0
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_vld_i,
  output logic      in_rdy_o,
  input  wire sq_t  in_i,
  output logic      out_vld_o,
  input  wire logic out_rdy_i,
  output sq_t       out_o
);
  localparam logic [SQ_W-1:0] BIT = SQ_W'(64'd1 << (62 - 2 * K));

  logic            vld_q;
  sq_t             data_q, data_d;
  logic [SQ_W-1:0] trial;

  always_comb begin
    data_d = in_i;
    trial  = in_i.root + BIT;
    if (in_i.rem >= trial) begin
      data_d.rem  = in_i.rem - trial;
      data_d.root = (in_i.root >> 1) + BIT;
    end else begin
      data_d.root = in_i.root >> 1;
    end
  end

  assign in_rdy_o  = !vld_q || out_rdy_i;
  assign out_vld_o = vld_q;
  assign out_o     = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_rdy_o) begin
      vld_q <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy_o && in_vld_i) begin
      data_q <= data_d;
    end
  end
endmodule
`default_nettype wire

// ----- design/qte_cordic_cell.sv -----
// One CORDIC vectoring micro-rotation on the roll, pitch and yaw lanes side by side.
`timescale 1ns / 1ps
`default_nettype none
module qte_cordic_cell import qte_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_vld_i,
  output logic      in_rdy_o,
  input  wire cd_t  in_i,
  output logic      out_vld_o,
  input  wire logic out_rdy_i,
  output cd_t       out_o
);
  localparam logic signed [ACC_W-1:0] ANG = atan_of(SHIFT);

  logic vld_q;
  cd_t  data_q, data_d;

  always_comb begin
    data_d = in_i;
    for (int l = 0; l < 3; l++) begin
      if (in_i.lane[l].y >= 0) begin
        data_d.lane[l].x   = in_i.lane[l].x + (in_i.lane[l].y >>> SHIFT);
        data_d.lane[l].y   = in_i.lane[l].y - (in_i.lane[l].x >>> SHIFT);
        data_d.lane[l].acc = in_i.lane[l].acc + ANG;
      end else begin
        data_d.lane[l].x   = in_i.lane[l].x - (in_i.lane[l].y >>> SHIFT);
        data_d.lane[l].y   = in_i.lane[l].y + (in_i.lane[l].x >>> SHIFT);
        data_d.lane[l].acc = in_i.lane[l].acc - ANG;
      end
    end
  end

  assign in_rdy_o  = !vld_q || out_rdy_i;
  assign out_vld_o = vld_q;
  assign out_o     = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_rdy_o) begin
      vld_q <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy_o && in_vld_i) begin
      data_q <= data_d;
    end
  end
endmodule
`default_nettype wire

// ----- design/quaternion_to_euler.sv -----
// Top level: quaternion in, ZYX roll/pitch/yaw out, through sqrt and CORDIC cell chains.
//
//  port      dir   transfer carries
//  quat_i    in    quat_x, quat_y, quat_z, quat_w (signed Q1.14)
//  euler_o   out   roll_angle, pitch_angle, yaw_angle, pitch_clamped
//
// One quaternion per cycle sustained while the output is not stalled. The stages are:
// products, sums/clamp, square, remainder, 32 root cells, quadrant fold, CORDIC cells,
// output register. Every stage holds its own valid, so bubbles close up under a stall
// and input keeps flowing until the whole chain is full. Reset empties all stages.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler import qte_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  qte_quat_if.sink    quat_i,
  qte_euler_if.source euler_o
);
  localparam int NS = (CORDIC_STAGES < 1) ? 1 :
                      (CORDIC_STAGES > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STAGES;

  // stage A: products
  logic                 a_vld_q, a_rdy;
  logic signed [PW-1:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, zx_q;
  // stage B: sums and pitch clamp
  logic    b_vld_q, b_rdy;
  sq_pay_t b_q, b_d;
  // stage C: square of the pitch sine
  logic                 c_vld_q, c_rdy;
  sq_pay_t              c_pay_q;
  logic [61:0]          c_sq_q;
  logic [31:0]          mag;
  // root chain
  logic        sv   [0:SQRT_ITER];
  logic        sr   [0:SQRT_ITER];
  sq_t         sd   [0:SQRT_ITER];
  logic        d_vld_q, d_rdy;
  sq_t         d_q;
  // CORDIC chain
  logic e_vld_q;
  cd_t  e_q, e_d;
  logic cv [0:NS];
  logic cr [0:NS];
  cd_t  cdat [0:NS];
  logic o_rdy;

  assign quat_i.ready = a_rdy;
  assign a_rdy = !a_vld_q || b_rdy;
  assign b_rdy = !b_vld_q || c_rdy;
  assign c_rdy = !c_vld_q || d_rdy;
  assign d_rdy = !d_vld_q || sr[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      if (a_rdy) a_vld_q <= quat_i.valid;
      if (b_rdy) b_vld_q <= a_vld_q;
      if (c_rdy) c_vld_q <= b_vld_q;
      if (d_rdy) d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && quat_i.valid) begin
      wx_q <= quat_i.quat_w * quat_i.quat_x;
      yz_q <= quat_i.quat_y * quat_i.quat_z;
      xx_q <= quat_i.quat_x * quat_i.quat_x;
      yy_q <= quat_i.quat_y * quat_i.quat_y;
      wz_q <= quat_i.quat_w * quat_i.quat_z;
      xy_q <= quat_i.quat_x * quat_i.quat_y;
      zz_q <= quat_i.quat_z * quat_i.quat_z;
      wy_q <= quat_i.quat_w * quat_i.quat_y;
      zx_q <= quat_i.quat_z * quat_i.quat_x;
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] sp;
    logic signed [SUM_W-1:0] s30w;
    b_d.sr = (SUM_W'(wx_q) + SUM_W'(yz_q)) <<< 1;
    b_d.cr = ONE - ((SUM_W'(xx_q) + SUM_W'(yy_q)) <<< 1);
    b_d.sy = (SUM_W'(wz_q) + SUM_W'(xy_q)) <<< 1;
    b_d.cy = ONE - ((SUM_W'(yy_q) + SUM_W'(zz_q)) <<< 1);
    sp     = (SUM_W'(wy_q) - SUM_W'(zx_q)) <<< 1;
    b_d.clamped = 1'b0;
    if (sp > ONE) begin
      sp = ONE;
      b_d.clamped = 1'b1;
    end else if (sp < -ONE) begin
      sp = -ONE;
      b_d.clamped = 1'b1;
    end
    s30w    = ((sp + RND) <<< SHL) >>> SHR;
    b_d.s30 = s30w[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (b_rdy && a_vld_q) b_q <= b_d;
  end

  assign mag = b_q.s30[31] ? -b_q.s30 : b_q.s30;

  always_ff @(posedge clk_i) begin
    if (c_rdy && b_vld_q) begin
      c_pay_q <= b_q;
      c_sq_q  <= mag[30:0] * mag[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_rdy && c_vld_q) begin
      d_q.rem  <= (SQ_W'(c_sq_q) >= FULL) ? '0 : FULL - SQ_W'(c_sq_q);
      d_q.root <= '0;
      d_q.pay  <= c_pay_q;
    end
  end

  assign sv[0] = d_vld_q;
  assign sd[0] = d_q;

  for (genvar k = 0; k < SQRT_ITER; k++) begin : g_sqrt
    qte_sqrt_cell #(.K(k)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .in_vld_i  (sv[k]),
      .in_rdy_o  (sr[k]),
      .in_i      (sd[k]),
      .out_vld_o (sv[k+1]),
      .out_rdy_i (sr[k+1]),
      .out_o     (sd[k+1])
    );
  end

  // sr[SQRT_ITER] is the ready from the quadrant fold register back into the root chain
  assign sr[SQRT_ITER] = !e_vld_q || cr[0];

  always_comb begin
    e_d.lane[0] = prerot(CW'(sd[SQRT_ITER].pay.sr), CW'(sd[SQRT_ITER].pay.cr));
    e_d.lane[1] = prerot(CW'(sd[SQRT_ITER].pay.s30), CW'(sd[SQRT_ITER].root[30:0]));
    e_d.lane[2] = prerot(CW'(sd[SQRT_ITER].pay.sy), CW'(sd[SQRT_ITER].pay.cy));
    e_d.clamped = sd[SQRT_ITER].pay.clamped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (sr[SQRT_ITER]) begin
      e_vld_q <= sv[SQRT_ITER];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sr[SQRT_ITER] && sv[SQRT_ITER]) e_q <= e_d;
  end

  assign cv[0]   = e_vld_q;
  assign cdat[0] = e_q;

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    qte_cordic_cell #(.SHIFT(i)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .in_vld_i  (cv[i]),
      .in_rdy_o  (cr[i]),
      .in_i      (cdat[i]),
      .out_vld_o (cv[i+1]),
      .out_rdy_i (cr[i+1]),
      .out_o     (cdat[i+1])
    );
  end

  assign o_rdy  = !euler_o.valid || euler_o.ready;
  assign cr[NS] = o_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      euler_o.valid <= 1'b0;
    end else if (o_rdy) begin
      euler_o.valid <= cv[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_rdy && cv[NS]) begin
      euler_o.roll_angle    <= to_angle(cdat[NS].lane[0]);
      euler_o.pitch_angle   <= to_angle(cdat[NS].lane[1]);
      euler_o.yaw_angle     <= to_angle(cdat[NS].lane[2]);
      euler_o.pitch_clamped <= cdat[NS].clamped;
    end
  end
endmodule
`default_nettype wire

// ----- design/qte_checker.sv -----
// Port-level checks for the quaternion to Euler converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module qte_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [48:0] out_payload_i
);
  logic [7:0] inflight_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + {7'd0, in_xfer} - {7'd0, out_xfer};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_payload_i))
    else $error("output payload changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> inflight_q != 8'd0)
    else $error("result without a pending quaternion");

  a_full_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input backpressure without an output stall");
endmodule

bind quaternion_to_euler qte_checker u_qte_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (quat_i.valid),
  .in_ready_i    (quat_i.ready),
  .out_valid_i   (euler_o.valid),
  .out_ready_i   (euler_o.ready),
  .out_payload_i ({euler_o.roll_angle, euler_o.pitch_angle, euler_o.yaw_angle,
                   euler_o.pitch_clamped})
);
`default_nettype wire

// ----- dv/tb.sv -----
// Testbench for the quaternion to ZYX Euler angle converter: directed table, random, scoreboard.
`timescale 1ns / 1ps
module tb;
  import qte_pkg::*;

  localparam int STAGES    = CORDIC_STAGES_DEF;
  localparam int LATENCY   = 4 + 32 + 1 + STAGES + 1;
  localparam int N_RANDOM  = 600;
  localparam int WD_LIMIT  = 20000;
  localparam int HOLD_LONG = 400;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [15:0] w;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic               clamped;
  } euler_t;

  typedef struct {
    quat_t  q;
    logic   known;
    euler_t e;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  qte_quat_if  quat_if ();
  qte_euler_if euler_if ();

  quaternion_to_euler #(.CORDIC_STAGES(STAGES)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .quat_i (quat_if.sink),
    .euler_o(euler_if.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  euler_t angles_pending[$];
  quat_t  stim_q[$];
  int     n_errors = 0;
  int     idle_cycles = 0;
  bit     stim_done = 1'b0;
  bit     hold_off = 1'b0;

  // ---------------- predictor ----------------
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_entry(int i);
    longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                      10679838, 5340245, 2670163, 1335087, 667544, 333772,
                      166886, 83443, 41722, 20861, 10430, 5215,
                      2608, 1304, 652, 326, 163, 81};
    return t[i];
  endfunction

  function automatic longint vector_angle(longint yi, longint xi);
    longint acc, x, y, dx, dy, t;
    int n;
    acc = 0;
    x = xi;
    y = yi;
    n = (STAGES < 1) ? 1 : (STAGES > 24 ? 24 : STAGES);
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; acc = 64'sd1 << 30;
      end else begin
        x = -y; y = t; acc = -(64'sd1 << 30);
      end
    end
    for (int i = 0; i < n; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; acc += atan_entry(i);
      end else begin
        x -= dx; y += dy; acc -= atan_entry(i);
      end
    end
    return acc;
  endfunction

  function automatic logic [15:0] binary_angle(longint acc);
    longint r;
    r = floor_shr(acc + 32768, 16);
    return r[15:0];
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic euler_t predict_euler(quat_t q);
    longint x, y, z, w, one, sr, cr, sy, cy, sp, s30, c30;
    longint unsigned mag, sq, full;
    euler_t e;
    x = q.x; y = q.y; z = q.z; w = q.w;
    one = 64'sd1 << (2 * FRAC_BITS);
    sr = 2 * (w * x + y * z);
    cr = one - 2 * (x * x + y * y);
    sy = 2 * (w * z + x * y);
    cy = one - 2 * (y * y + z * z);
    sp = 2 * (w * y - z * x);
    e.clamped = 1'b0;
    if (sp > one) begin
      sp = one; e.clamped = 1'b1;
    end else if (sp < -one) begin
      sp = -one; e.clamped = 1'b1;
    end
    if (2 * FRAC_BITS > 30)
      s30 = floor_shr(sp + (64'sd1 << (2 * FRAC_BITS - 31)), 2 * FRAC_BITS - 30);
    else
      s30 = sp <<< (30 - 2 * FRAC_BITS);
    mag = (s30 < 0) ? -s30 : s30;
    full = 64'd1 << 60;
    sq = mag * mag;
    c30 = int_sqrt(sq >= full ? 64'd0 : full - sq);
    e.roll  = binary_angle(vector_angle(sr, cr));
    e.pitch = binary_angle(vector_angle(s30, c30));
    e.yaw   = binary_angle(vector_angle(sy, cy));
    return e;
  endfunction

  // ---------------- stimulus build ----------------
  function automatic logic signed [15:0] rand_comp();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'(16384);
    if (r == 1) return -16'sd16384;
    if (r == 2) return 16'($urandom);   // full 16-bit noise, non-unit
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // near-unit quaternion from random components, normalized in real arithmetic
  function automatic quat_t rand_unit_quat();
    real a, b, c, d, n;
    quat_t q;
    a = $signed($urandom_range(0, 2000)) - 1000;
    b = $signed($urandom_range(0, 2000)) - 1000;
    c = $signed($urandom_range(0, 2000)) - 1000;
    d = $signed($urandom_range(0, 2000)) - 1000;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n == 0.0) begin
      a = 1.0; n = 1.0;
    end
    q.x = $rtoi(a / n * 16384.0);
    q.y = $rtoi(b / n * 16384.0);
    q.z = $rtoi(c / n * 16384.0);
    q.w = $rtoi(d / n * 16384.0);
    return q;
  endfunction

  dir_row_t dir_table[$];

  function automatic dir_row_t row(int x, int y, int z, int w, logic known,
                                   int r, int p, int yw, logic c);
    dir_row_t d;
    d.q = '{16'(x), 16'(y), 16'(z), 16'(w)};
    d.known = known;
    d.e = '{16'(r), 16'(p), 16'(yw), c};
    return d;
  endfunction

  initial begin
    // identity, negated identity and all-zero: every angle zero
    dir_table.push_back(row(0, 0, 0, 16384, 1, 0, 0, 0, 0));
    dir_table.push_back(row(0, 0, 0, 0, 1, 0, 0, 0, 0));
    dir_table.push_back(row(0, 0, 0, -16384, 1, 0, 0, 0, 0));
    // half turns about each axis: roll/yaw of exactly pi wrap
    dir_table.push_back(row(16384, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_table.push_back(row(0, 16384, 0, 0, 0, 0, 0, 0, 0));
    dir_table.push_back(row(0, 0, 16384, 0, 0, 0, 0, 0, 0));
    dir_table.push_back(row(-16384, 0, 0, 0, 0, 0, 0, 0, 0));
    // gimbal lock, pitch at +-pi/2
    dir_table.push_back(row(0, 11585, 0, 11585, 0, 0, 0, 0, 0));
    dir_table.push_back(row(0, -11585, 0, 11585, 0, 0, 0, 0, 0));
    // sine out of range both ways; the last row is non-unit with a zero sine
    dir_table.push_back(row(0, 16384, 0, 16384, 0, 0, 0, 0, 0));
    dir_table.push_back(row(0, -16384, 0, 16384, 0, 0, 0, 0, 0));
    dir_table.push_back(row(-16384, 16384, 16384, 16384, 0, 0, 0, 0, 0));
    dir_table.push_back(row(16384, 16384, -16384, -16384, 0, 0, 0, 0, 0));
    // raw field extremes and tiny values, non-unit
    dir_table.push_back(row(-32768, -32768, -32768, -32768, 0, 0, 0, 0, 0));
    dir_table.push_back(row(32767, 32767, 32767, 32767, 0, 0, 0, 0, 0));
    dir_table.push_back(row(32767, -32768, 32767, -32768, 0, 0, 0, 0, 0));
    dir_table.push_back(row(-1, -1, -1, -1, 0, 0, 0, 0, 0));
    dir_table.push_back(row(1, 1, 1, 1, 0, 0, 0, 0, 0));
    // quarter turns
    dir_table.push_back(row(11585, 0, 0, 11585, 0, 0, 0, 0, 0));
    dir_table.push_back(row(0, 0, 11585, 11585, 0, 0, 0, 0, 0));
    dir_table.push_back(row(0, 0, -11585, 11585, 0, 0, 0, 0, 0));
    dir_table.push_back(row(-11585, 0, 0, 11585, 0, 0, 0, 0, 0));
  end

  // ---------------- sender ----------------
  initial begin
    quat_t q;
    int burst, gap, k;
    quat_if.valid  = 1'b0;
    quat_if.quat_x = '0;
    quat_if.quat_y = '0;
    quat_if.quat_z = '0;
    quat_if.quat_w = '0;
    #0;
    foreach (dir_table[i]) stim_q.push_back(dir_table[i].q);
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        q.x = rand_comp(); q.y = rand_comp(); q.z = rand_comp(); q.w = rand_comp();
      end else begin
        q = rand_unit_quat();
      end
      stim_q.push_back(q);
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    k = 0;
    while (k < stim_q.size()) begin
      burst = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      while (burst > 0 && k < stim_q.size()) begin
        quat_if.valid  <= 1'b1;
        quat_if.quat_x <= stim_q[k].x;
        quat_if.quat_y <= stim_q[k].y;
        quat_if.quat_z <= stim_q[k].z;
        quat_if.quat_w <= stim_q[k].w;
        @(posedge clk_i);
        while (!quat_if.ready) @(posedge clk_i);
        k++;
        burst--;
      end
      if (gap > 0 && k < stim_q.size()) begin
        quat_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    quat_if.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // expected results are queued at the input transfer
  int n_in = 0;
  always @(posedge clk_i) begin
    if (rst_ni && quat_if.valid && quat_if.ready) begin
      quat_t q;
      euler_t e;
      q = '{quat_if.quat_x, quat_if.quat_y, quat_if.quat_z, quat_if.quat_w};
      e = predict_euler(q);
      if (n_in < dir_table.size() && dir_table[n_in].known && e != dir_table[n_in].e) begin
        n_errors++;
        if (n_errors <= 10)
          $display("table row %0d: predictor %h disagrees with table %h",
                   n_in, e, dir_table[n_in].e);
      end
      angles_pending.push_back(e);
      n_in++;
    end
  end

  // ---------------- receiver ----------------
  initial begin
    int hold_at;
    euler_if.ready = 1'b0;
    hold_at = $urandom_range(100, 300);
    @(posedge rst_ni);
    for (int c = 0; ; c++) begin
      if (c == hold_at) begin
        euler_if.ready <= 1'b0;
        hold_off = 1'b1;
        repeat (HOLD_LONG) @(posedge clk_i);
        hold_off = 1'b0;
      end
      if (c < 60 || (c / 50) % 3 == 0)
        euler_if.ready <= 1'b1;
      else
        euler_if.ready <= ($urandom_range(0, 3) != 0);
      @(posedge clk_i);
    end
  end

  // ---------------- checker ----------------
  always @(posedge clk_i) begin
    if (rst_ni && euler_if.valid && euler_if.ready) begin
      euler_t got, want;
      got = '{euler_if.roll_angle, euler_if.pitch_angle, euler_if.yaw_angle,
              euler_if.pitch_clamped};
      if (angles_pending.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = angles_pending.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d clamp %0b/%0b (exp/act)",
                     want.roll, got.roll, want.pitch, got.pitch, want.yaw, got.yaw,
                     want.clamped, got.clamped);
        end
      end
    end
  end

  // watchdog: cycles without any transfer outside the long receiver hold
  always @(posedge clk_i) begin
    if ((quat_if.valid && quat_if.ready) || (euler_if.valid && euler_if.ready) || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (!(stim_done && angles_pending.size() == 0) && idle_cycles < WD_LIMIT)
      @(posedge clk_i);
    if (idle_cycles >= WD_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      repeat (LATENCY * 2) @(posedge clk_i);
      if (n_errors == 0 && angles_pending.size() == 0)
        $display("Simulation PASSED");
      else
        $display("Simulation FAILED");
      $finish;
    end
  end
endmodule
